@@ src/hrpg_pkg.sv @@
// ----------------------------------------------------------------------------
// hrpg_pkg
// Shared types, widths and helper functions of the hexahedron raster point
// generator: item structs, register indexes, coefficient forming and output
// saturation.
// ----------------------------------------------------------------------------
`default_nettype none

package hrpg_pkg;

  localparam int unsigned COORD_BITS  = 24;
  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned PAR_W       = FRAC_BITS + 1;
  localparam int unsigned COEF_W      = COORD_BITS + 3;
  localparam int unsigned MUL_B_W     = PAR_W + 1;
  localparam int unsigned MUL_W       = COEF_W + MUL_B_W;
  localparam int unsigned ACC_W       = MUL_W + 3;
  localparam int unsigned SAT_W       = ACC_W - FRAC_BITS;
  localparam int unsigned NUM_CORNERS = 8;
  localparam int unsigned NUM_AXES    = 3;
  localparam int unsigned NUM_TERMS   = 7;
  localparam int unsigned STEP_W      = 17;
  localparam int unsigned CFG_DATA_W  = 17;
  localparam int unsigned CFG_ADDR_W  = 1;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned DEF_MAX_EDGE_POINTS = 256;
  localparam int unsigned STEP_RESET          = 6554;
  localparam int unsigned EDGE_RESET          = 11;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_STEP_SIZE   = 1'b0,
    CFG_EDGE_POINTS = 1'b1
  } cfg_addr_e;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_EMIT = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_PARAM,
    BK_MAC,
    BK_DRAIN
  } back_state_e;

  typedef struct packed {
    logic                         cmd;
    logic [2:0]                   corner_index;
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;
    logic signed [COORD_BITS-1:0] coord_z;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic signed [COORD_BITS-1:0] point_z;
    logic                         last_point;
  } out_item_t;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic [NUM_CORNERS-1:0][COORD_BITS-1:0] corner_set_t;
  typedef corner_set_t [NUM_AXES-1:0] corner_store_t;

  localparam logic signed [SAT_W-1:0] SAT_HI =
    {{(SAT_W-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [SAT_W-1:0] SAT_LO =
    {{(SAT_W-COORD_BITS+1){1'b1}}, {(COORD_BITS-1){1'b0}}};

  // coefficient of term 1..7 (index 0..6) for one axis
  function automatic coef_t coef_term(input corner_set_t c, input logic [2:0] term);
    coef_t e0, e1, e2, e3, e4, e5, e6, e7;
    coef_t k;
    e0 = coef_t'($signed(c[0]));
    e1 = coef_t'($signed(c[1]));
    e2 = coef_t'($signed(c[2]));
    e3 = coef_t'($signed(c[3]));
    e4 = coef_t'($signed(c[4]));
    e5 = coef_t'($signed(c[5]));
    e6 = coef_t'($signed(c[6]));
    e7 = coef_t'($signed(c[7]));
    case (term)
      3'd0:    k = e1 - e0;
      3'd1:    k = e2 - e0;
      3'd2:    k = e4 - e0;
      3'd3:    k = e3 - e1 - e2 + e0;
      3'd4:    k = e5 - e1 - e4 + e0;
      3'd5:    k = e6 - e2 - e4 + e0;
      3'd6:    k = e7 - e0 + e1 + e2 - e3 + e4 - e5 - e6;
      default: k = '0;
    endcase
    return k;
  endfunction

  // floor to a signed 24-bit integer (q23.0) and clamp to the coordinate range
  function automatic logic [COORD_BITS-1:0] sat_coord(input logic signed [ACC_W-1:0] acc);
    logic signed [SAT_W-1:0] sh;
    logic [COORD_BITS-1:0]   res;
    sh = $signed(acc[ACC_W-1:FRAC_BITS]);
    if (sh > SAT_HI) begin
      res = SAT_HI[COORD_BITS-1:0];
    end else if (sh < SAT_LO) begin
      res = SAT_LO[COORD_BITS-1:0];
    end else begin
      res = sh[COORD_BITS-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

@@ src/hexahedron_raster_point_generator.sv @@
// ----------------------------------------------------------------------------
// hexahedron_raster_point_generator
// Emit: new emits are queued while the back part works on one emit at a
// time on the shared multiplier (7 parameter products, 21 coefficient products).
// Load: it waits until queued and running emits are done.
// Reset: corners and lattice counters zero, step 6554, edge points 11.
// Fills a hexahedron with a trilinear point raster, w fastest, then u, then v.
// ----------------------------------------------------------------------------
`default_nettype none

module hexahedron_raster_point_generator #(
  parameter int unsigned MAX_EDGE_POINTS = hrpg_pkg::DEF_MAX_EDGE_POINTS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [hrpg_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [hrpg_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            in_valid_i,
  input  hrpg_pkg::in_item_t              in_data_i,
  output logic                            in_stall_o,
  output logic                            out_valid_o,
  output hrpg_pkg::out_item_t             out_data_o,
  input  logic                            out_stall_i
);

  localparam int unsigned JOB_W = 3 * $clog2(MAX_EDGE_POINTS) + 1;

  logic                        q_push, q_pop, q_full, q_empty;
  logic [JOB_W-1:0]            q_wdata, q_rdata;
  logic                        back_busy;
  hrpg_pkg::corner_store_t     corners;
  logic [hrpg_pkg::STEP_W-1:0] step_size;

  hrpg_front #(
    .MAX_EDGE_POINTS(MAX_EDGE_POINTS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .q_full_i    (q_full),
    .q_empty_i   (q_empty),
    .q_push_o    (q_push),
    .q_data_o    (q_wdata),
    .back_busy_i (back_busy),
    .corners_o   (corners),
    .step_size_o (step_size)
  );

  hrpg_fifo #(
    .WIDTH(JOB_W),
    .DEPTH(hrpg_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  hrpg_back #(
    .MAX_EDGE_POINTS(MAX_EDGE_POINTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_size_i (step_size),
    .corners_i   (corners),
    .q_empty_i   (q_empty),
    .q_data_i    (q_rdata),
    .q_pop_o     (q_pop),
    .busy_o      (back_busy),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

endmodule

`default_nettype wire

@@ src/hrpg_fifo.sv @@
// ----------------------------------------------------------------------------
// hrpg_fifo
// Small flop based queue that carries raster jobs from the front part to the
// back part.
// ----------------------------------------------------------------------------
`default_nettype none

module hrpg_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

@@ src/hrpg_front.sv @@
// ----------------------------------------------------------------------------
// hrpg_front
// Front part: configuration registers, corner store, lattice index counters.
// Takes input transfers, writes corners and queues one job per emit.
// ----------------------------------------------------------------------------
`default_nettype none

module hrpg_front #(
  parameter int unsigned MAX_EDGE_POINTS = hrpg_pkg::DEF_MAX_EDGE_POINTS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [hrpg_pkg::CFG_ADDR_W-1:0]     cfg_addr_i,
  input  logic [hrpg_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                                in_valid_i,
  input  hrpg_pkg::in_item_t                  in_data_i,
  output logic                                in_stall_o,
  input  logic                                q_full_i,
  input  logic                                q_empty_i,
  output logic                                q_push_o,
  output logic [3*$clog2(MAX_EDGE_POINTS):0]  q_data_o,
  input  logic                                back_busy_i,
  output hrpg_pkg::corner_store_t             corners_o,
  output logic [hrpg_pkg::STEP_W-1:0]         step_size_o
);

  localparam int unsigned IDX_W = $clog2(MAX_EDGE_POINTS);
  localparam int unsigned DW    = hrpg_pkg::CFG_DATA_W;

  logic [hrpg_pkg::STEP_W-1:0] step_q;
  logic [DW-1:0]               edge_q;
  hrpg_pkg::corner_store_t     corner_q;
  logic [IDX_W-1:0]            u_q, v_q, w_q;
  logic [IDX_W-1:0]            last_idx;
  logic                        u_end, v_end, w_end, fin;
  logic                        accept, is_emit;

  assign is_emit = (in_data_i.cmd == hrpg_pkg::CMD_EMIT);

  always_comb begin
    if (is_emit) begin
      in_stall_o = q_full_i;
    end else begin
      // loads wait until no earlier point still reads the corners
      in_stall_o = !(q_empty_i && !back_busy_i);
    end
  end

  assign accept = in_valid_i && !in_stall_o;

  always_comb begin
    if (edge_q == '0) begin
      last_idx = '0;
    end else if (32'(edge_q) > 32'(MAX_EDGE_POINTS)) begin
      last_idx = IDX_W'(MAX_EDGE_POINTS - 1);
    end else begin
      last_idx = IDX_W'(edge_q - 1'b1);
    end
  end

  assign w_end = (w_q >= last_idx);
  assign u_end = (u_q >= last_idx);
  assign v_end = (v_q >= last_idx);
  assign fin   = w_end && u_end && v_end;

  assign q_push_o    = accept && is_emit;
  assign q_data_o    = {fin, v_q, u_q, w_q};
  assign corners_o   = corner_q;
  assign step_size_o = step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= hrpg_pkg::STEP_W'(hrpg_pkg::STEP_RESET);
      edge_q <= DW'(hrpg_pkg::EDGE_RESET);
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        hrpg_pkg::CFG_STEP_SIZE:   step_q <= cfg_wdata_i;
        hrpg_pkg::CFG_EDGE_POINTS: edge_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      corner_q <= '0;
    end else if (accept && !is_emit) begin
      corner_q[0][in_data_i.corner_index] <= in_data_i.coord_x;
      corner_q[1][in_data_i.corner_index] <= in_data_i.coord_y;
      corner_q[2][in_data_i.corner_index] <= in_data_i.coord_z;
    end
  end

  // w fastest, then u, then v
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u_q <= '0;
      v_q <= '0;
      w_q <= '0;
    end else if (q_push_o) begin
      if (w_end) begin
        w_q <= '0;
        if (u_end) begin
          u_q <= '0;
          v_q <= v_end ? '0 : v_q + 1'b1;
        end else begin
          u_q <= u_q + 1'b1;
        end
      end else begin
        w_q <= w_q + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ src/hrpg_back.sv @@
// ----------------------------------------------------------------------------
// hrpg_back
// Back part: one shared signed multiplier forms the seven lattice parameters,
// then runs 21 coefficient products through a short pipeline into three
// accumulators, then floors, saturates and registers the raster point.
// ----------------------------------------------------------------------------
`default_nettype none

module hrpg_back #(
  parameter int unsigned MAX_EDGE_POINTS = hrpg_pkg::DEF_MAX_EDGE_POINTS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [hrpg_pkg::STEP_W-1:0]        step_size_i,
  input  hrpg_pkg::corner_store_t            corners_i,
  input  logic                               q_empty_i,
  input  logic [3*$clog2(MAX_EDGE_POINTS):0] q_data_i,
  output logic                               q_pop_o,
  output logic                               busy_o,
  output logic                               out_valid_o,
  output hrpg_pkg::out_item_t                out_data_o,
  input  logic                               out_stall_i
);

  localparam int unsigned IDX_W  = $clog2(MAX_EDGE_POINTS);
  localparam int unsigned PAR_W  = hrpg_pkg::PAR_W;
  localparam int unsigned COEF_W = hrpg_pkg::COEF_W;
  localparam int unsigned MB_W   = hrpg_pkg::MUL_B_W;
  localparam int unsigned MUL_W  = hrpg_pkg::MUL_W;
  localparam int unsigned ACC_W  = hrpg_pkg::ACC_W;
  localparam int unsigned FRAC   = hrpg_pkg::FRAC_BITS;
  localparam int unsigned NAX    = hrpg_pkg::NUM_AXES;
  localparam int unsigned NTERM  = hrpg_pkg::NUM_TERMS;

  localparam logic [2:0]              LAST_TERM = 3'(NTERM - 1);
  localparam logic [1:0]              LAST_AXIS = 2'(NAX - 1);
  localparam logic [PAR_W-1:0]        PAR_ONE   = PAR_W'(1) << FRAC;
  localparam logic signed [MUL_W-1:0] ONE_WIDE  = MUL_W'(PAR_ONE);

  hrpg_pkg::back_state_e state_q, state_d;

  logic [IDX_W-1:0]         u_q, v_q, w_q;
  logic                     last_q;
  logic [PAR_W-1:0]         par_q [NTERM];
  logic [2:0]               term_q;
  logic [1:0]               axis_q;
  logic                     s1_valid_q, s2_valid_q;
  logic [1:0]               s1_axis_q, s2_axis_q;
  hrpg_pkg::coef_t          k_q;
  logic [PAR_W-1:0]         p_q;
  logic signed [MUL_W-1:0]  prod_q;
  logic signed [ACC_W-1:0]  acc_q [NAX];
  logic                     out_valid_q;
  hrpg_pkg::out_item_t      out_data_q;

  logic signed [COEF_W-1:0] mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [MUL_W-1:0]  mul_p;
  logic [PAR_W-1:0]         par_res;
  logic                     out_free, out_load;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign busy_o      = (state_q != hrpg_pkg::BK_IDLE);

  // shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (s1_valid_q) begin
      mul_a = k_q;
      mul_b = $signed({1'b0, p_q});
    end else begin
      case (term_q)
        3'd0: begin
          mul_a = COEF_W'(u_q);
          mul_b = MB_W'(step_size_i);
        end
        3'd1: begin
          mul_a = COEF_W'(v_q);
          mul_b = MB_W'(step_size_i);
        end
        3'd2: begin
          mul_a = COEF_W'(w_q);
          mul_b = MB_W'(step_size_i);
        end
        3'd3: begin
          mul_a = COEF_W'(par_q[0]);
          mul_b = MB_W'(par_q[1]);
        end
        3'd4: begin
          mul_a = COEF_W'(par_q[0]);
          mul_b = MB_W'(par_q[2]);
        end
        3'd5: begin
          mul_a = COEF_W'(par_q[1]);
          mul_b = MB_W'(par_q[2]);
        end
        3'd6: begin
          mul_a = COEF_W'(par_q[3]);
          mul_b = MB_W'(par_q[2]);
        end
        default: begin
          mul_a = '0;
          mul_b = '0;
        end
      endcase
    end
    mul_p = mul_a * mul_b;
  end

  // lattice coordinates clamp at one, products keep q1.16
  always_comb begin
    if (term_q < 3'd3) begin
      par_res = (mul_p > ONE_WIDE) ? PAR_ONE : mul_p[PAR_W-1:0];
    end else begin
      par_res = mul_p[FRAC +: PAR_W];
    end
  end

  always_comb begin
    state_d  = state_q;
    q_pop_o  = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      hrpg_pkg::BK_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          state_d = hrpg_pkg::BK_PARAM;
        end
      end
      hrpg_pkg::BK_PARAM: begin
        if (term_q == LAST_TERM) begin
          state_d = hrpg_pkg::BK_MAC;
        end
      end
      hrpg_pkg::BK_MAC: begin
        if (axis_q == LAST_AXIS && term_q == LAST_TERM) begin
          state_d = hrpg_pkg::BK_DRAIN;
        end
      end
      hrpg_pkg::BK_DRAIN: begin
        if (!s1_valid_q && !s2_valid_q && out_free) begin
          out_load = 1'b1;
          state_d  = hrpg_pkg::BK_IDLE;
        end
      end
      default: state_d = hrpg_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hrpg_pkg::BK_IDLE;
      term_q      <= '0;
      axis_q      <= '0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      s1_valid_q <= (state_q == hrpg_pkg::BK_MAC);
      s2_valid_q <= s1_valid_q;
      if (q_pop_o) begin
        term_q <= '0;
      end else if (state_q == hrpg_pkg::BK_PARAM) begin
        term_q <= (term_q == LAST_TERM) ? '0 : term_q + 1'b1;
        axis_q <= '0;
      end else if (state_q == hrpg_pkg::BK_MAC) begin
        if (term_q == LAST_TERM) begin
          term_q <= '0;
          axis_q <= axis_q + 1'b1;
        end else begin
          term_q <= term_q + 1'b1;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      {last_q, v_q, u_q, w_q} <= q_data_i;
    end
    if (state_q == hrpg_pkg::BK_PARAM) begin
      par_q[term_q] <= par_res;
      if (term_q == LAST_TERM) begin
        // start each sum at corner 0 scaled to the product grid
        for (int a = 0; a < NAX; a++) begin
          acc_q[a] <= ACC_W'($signed(corners_i[a][0])) <<< FRAC;
        end
      end
    end
    if (state_q == hrpg_pkg::BK_MAC) begin
      k_q       <= hrpg_pkg::coef_term(corners_i[axis_q], term_q);
      p_q       <= par_q[term_q];
      s1_axis_q <= axis_q;
    end
    if (s1_valid_q) begin
      prod_q    <= mul_p;
      s2_axis_q <= s1_axis_q;
    end
    if (s2_valid_q) begin
      acc_q[s2_axis_q] <= acc_q[s2_axis_q] + ACC_W'(prod_q);
    end
    if (out_load) begin
      out_data_q.point_x    <= hrpg_pkg::sat_coord(acc_q[0]);
      out_data_q.point_y    <= hrpg_pkg::sat_coord(acc_q[1]);
      out_data_q.point_z    <= hrpg_pkg::sat_coord(acc_q[2]);
      out_data_q.last_point <= last_q;
    end
  end

endmodule

`default_nettype wire

@@ tb/hexahedron_raster_point_generator_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hexahedron_raster_point_generator_test
// Self-checking testbench: loads hexahedron corners, walks raster passes under
// many step and edge settings, and compares every point with a trilinear
// predictor kept in a scoreboard, under several sender and receiver idle mixes.
// ----------------------------------------------------------------------------
module hexahedron_raster_point_generator_test;

  localparam int unsigned HALF_PERIOD   = 6;
  localparam int unsigned RESET_CYCLES  = 8;
  localparam int unsigned SETTLE_CYCLES = 48;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned STALL_LIMIT   = 4000;
  localparam int unsigned PHASE_ITEMS   = 400;
  localparam int unsigned COORD_W       = hrpg_pkg::COORD_BITS;
  localparam int unsigned CFG_W         = hrpg_pkg::CFG_DATA_W;
  localparam longint      P_ONE         = longint'(1) << hrpg_pkg::FRAC_BITS;

  localparam logic signed [COORD_W-1:0] COORD_HI = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_LO = {1'b1, {(COORD_W-1){1'b0}}};

  class raster_tracker;
    hrpg_pkg::corner_store_t corners;
    int unsigned             w_idx, u_idx, v_idx;
    int unsigned             step_reg, edge_reg;
    hrpg_pkg::out_item_t     expected_points [$];
    int unsigned             mismatches, loads_seen, points_checked, ends_flagged;

    function new();
      corners        = '0;
      w_idx          = 0;
      u_idx          = 0;
      v_idx          = 0;
      step_reg       = hrpg_pkg::STEP_RESET;
      edge_reg       = hrpg_pkg::EDGE_RESET;
      mismatches     = 0;
      loads_seen     = 0;
      points_checked = 0;
      ends_flagged   = 0;
    endfunction

    function void write_register(hrpg_pkg::cfg_addr_e addr, logic [CFG_W-1:0] data);
      if (addr == hrpg_pkg::CFG_STEP_SIZE) begin
        step_reg = data;
      end else begin
        edge_reg = data;
      end
    endfunction

    function longint lattice(int unsigned idx);
      longint p;
      p = longint'(idx) * longint'(step_reg);
      return (p > P_ONE) ? P_ONE : p;
    endfunction

    function void take_command(hrpg_pkg::in_item_t cmd_item);
      longint              par [7];
      longint              c [8];
      longint              k [8];
      longint              ps, pt, pr, st, acc, res;
      int unsigned         n, last;
      hrpg_pkg::out_item_t point;
      if (cmd_item.cmd == hrpg_pkg::CMD_LOAD) begin
        corners[0][cmd_item.corner_index] = cmd_item.coord_x;
        corners[1][cmd_item.corner_index] = cmd_item.coord_y;
        corners[2][cmd_item.corner_index] = cmd_item.coord_z;
        loads_seen++;
        return;
      end
      ps     = lattice(u_idx);
      pt     = lattice(v_idx);
      pr     = lattice(w_idx);
      st     = (ps * pt) >> hrpg_pkg::FRAC_BITS;
      par[0] = ps;
      par[1] = pt;
      par[2] = pr;
      par[3] = st;
      par[4] = (ps * pr) >> hrpg_pkg::FRAC_BITS;
      par[5] = (pt * pr) >> hrpg_pkg::FRAC_BITS;
      par[6] = (st * pr) >> hrpg_pkg::FRAC_BITS;
      point  = '0;
      for (int ax = 0; ax < hrpg_pkg::NUM_AXES; ax++) begin
        for (int i = 0; i < hrpg_pkg::NUM_CORNERS; i++) begin
          c[i] = $signed(corners[ax][i]);
        end
        k[1] = c[1] - c[0];
        k[2] = c[2] - c[0];
        k[3] = c[4] - c[0];
        k[4] = c[3] - c[1] - c[2] + c[0];
        k[5] = c[5] - c[1] - c[4] + c[0];
        k[6] = c[6] - c[2] - c[4] + c[0];
        k[7] = c[7] - c[0] + c[1] + c[2] - c[3] + c[4] - c[5] - c[6];
        acc  = 0;
        for (int i = 1; i < 8; i++) begin
          acc += k[i] * par[i-1];
        end
        res = c[0] + (acc >>> hrpg_pkg::FRAC_BITS);
        if (res > longint'(COORD_HI)) res = longint'(COORD_HI);
        if (res < longint'(COORD_LO)) res = longint'(COORD_LO);
        case (ax)
          0:       point.point_x = res[COORD_W-1:0];
          1:       point.point_y = res[COORD_W-1:0];
          default: point.point_z = res[COORD_W-1:0];
        endcase
      end
      n = edge_reg;
      if (n < 1) n = 1;
      if (n > hrpg_pkg::DEF_MAX_EDGE_POINTS) n = hrpg_pkg::DEF_MAX_EDGE_POINTS;
      last = n - 1;
      point.last_point = (w_idx >= last) && (u_idx >= last) && (v_idx >= last);
      expected_points.push_back(point);
      if (w_idx >= last) begin
        w_idx = 0;
        if (u_idx >= last) begin
          u_idx = 0;
          if (v_idx >= last) v_idx = 0;
          else v_idx++;
        end else begin
          u_idx++;
        end
      end else begin
        w_idx++;
      end
    endfunction

    function void check_field(string name, logic signed [COORD_W:0] want,
                              logic signed [COORD_W:0] got);
      if (want !== got) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void compare_point(hrpg_pkg::out_item_t got);
      hrpg_pkg::out_item_t want;
      points_checked++;
      if (got.last_point) ends_flagged++;
      if (expected_points.size() == 0) begin
        mismatches++;
        $display("%0t: point with no emit pending, expected none, actual %0d %0d %0d %0b",
                 $time, got.point_x, got.point_y, got.point_z, got.last_point);
        return;
      end
      want = expected_points.pop_front();
      check_field("point_x", want.point_x, got.point_x);
      check_field("point_y", want.point_y, got.point_y);
      check_field("point_z", want.point_z, got.point_z);
      check_field("last_point", want.last_point, got.last_point);
    endfunction
  endclass

  logic                            clk_i       = 1'b0;
  logic                            rst_ni      = 1'b0;
  logic                            cfg_we_i    = 1'b0;
  logic [hrpg_pkg::CFG_ADDR_W-1:0] cfg_addr_i  = '0;
  logic [CFG_W-1:0]                cfg_wdata_i = '0;
  logic                            in_valid_i  = 1'b0;
  hrpg_pkg::in_item_t              in_data_i   = '0;
  logic                            in_stall_o;
  logic                            out_valid_o;
  hrpg_pkg::out_item_t             out_data_o;
  logic                            out_stall_i = 1'b0;

  raster_tracker tracker;
  int unsigned   send_idle_pct  = 0;
  int unsigned   recv_stall_pct = 0;
  int unsigned   hold_requests  = 0;
  int unsigned   hold_seen      = 0;
  int unsigned   hold_left      = 0;
  int unsigned   quiet_cycles   = 0;
  int unsigned   settings_used  = 0;

  hexahedron_raster_point_generator DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  always @(negedge clk_i) begin
    if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left   = hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) tracker.compare_point(out_data_o);
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic logic signed [COORD_W-1:0] random_coord();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick == 0) return COORD_HI;
    if (pick == 1) return COORD_LO;
    if (pick < 6) return COORD_W'($urandom_range(131071) - 65536);
    return COORD_W'($urandom);
  endfunction

  function automatic hrpg_pkg::in_item_t make_item(input hrpg_pkg::cmd_e op,
                                                   input logic [2:0] corner);
    hrpg_pkg::in_item_t item;
    item.cmd          = op;
    item.corner_index = corner;
    item.coord_x      = random_coord();
    item.coord_y      = random_coord();
    item.coord_z      = random_coord();
    return item;
  endfunction

  task automatic send_item(input hrpg_pkg::in_item_t item);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    tracker.take_command(item);
  endtask

  task automatic drain_points();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (tracker.expected_points.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_register(input hrpg_pkg::cfg_addr_e addr,
                                  input logic [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    tracker.write_register(addr, data);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_raster(input int unsigned step, input int unsigned points);
    program_register(hrpg_pkg::CFG_STEP_SIZE, CFG_W'(step));
    program_register(hrpg_pkg::CFG_EDGE_POINTS, CFG_W'(points));
    settings_used++;
  endtask

  task automatic send_emits(input int unsigned count);
    repeat (count) send_item(make_item(hrpg_pkg::CMD_EMIT, 3'($urandom_range(7))));
  endtask

  initial begin
    hrpg_pkg::in_item_t item;
    int unsigned        phase_items, seg, pick, n, step, points, emits, first;
    tracker = new();
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // all corners still zero after reset
    send_emits(1);
    for (int ci = 0; ci < hrpg_pkg::NUM_CORNERS; ci++) begin
      item         = make_item(hrpg_pkg::CMD_LOAD, 3'(ci));
      item.coord_x = ci[0] ? COORD_LO : COORD_HI;
      item.coord_y = ci[1] ? COORD_LO : COORD_HI;
      item.coord_z = ci[2] ? COORD_HI : COORD_LO;
      send_item(item);
    end
    send_emits(2);
    // edge shrinks mid pass, and coordinates run past one
    drain_points();
    set_raster(65536, 3);
    send_emits(3);
    // zero step
    drain_points();
    set_raster(0, 3);
    send_emits(2);
    // single point per edge
    drain_points();
    set_raster(hrpg_pkg::STEP_RESET, 0);
    send_emits(2);
    drain_points();
    set_raster(hrpg_pkg::STEP_RESET, 1);
    send_emits(1);
    // edge above the maximum, step above one
    drain_points();
    set_raster(131071, 300);
    send_emits(2);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 65;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 65;
        end
        default: begin
          send_idle_pct  = 10;
          recv_stall_pct = 10;
        end
      endcase
      phase_items = 0;
      seg         = 0;
      while (phase_items < PHASE_ITEMS) begin
        drain_points();
        pick = $urandom_range(9);
        if (pick < 7) begin
          n      = $urandom_range(2, 4);
          step   = 65536 / (n - 1) - $urandom_range(0, 20);
          points = n;
          emits  = n * n * n + $urandom_range(n * n * n);
        end else if (pick == 7) begin
          step   = $urandom_range(131071);
          points = $urandom_range(511);
          emits  = $urandom_range(4, 30);
        end else begin
          case ($urandom_range(3))
            0:       step = 0;
            1:       step = 1;
            2:       step = 65536;
            default: step = 131071;
          endcase
          case ($urandom_range(3))
            0:       points = 1;
            1:       points = 2;
            2:       points = 256;
            default: points = 511;
          endcase
          emits = $urandom_range(4, 30);
        end
        set_raster(step, points);
        first = $urandom_range(7);
        for (int j = 0; j < hrpg_pkg::NUM_CORNERS; j++) begin
          send_item(make_item(hrpg_pkg::CMD_LOAD, 3'(first + j)));
        end
        phase_items += hrpg_pkg::NUM_CORNERS;
        // long receiver hold-off while emits keep coming
        if (seg == 0) hold_requests++;
        for (int e = 0; e < emits; e++) begin
          if ($urandom_range(99) < 8) begin
            send_item(make_item(hrpg_pkg::CMD_LOAD, 3'($urandom_range(7))));
            phase_items++;
          end
          send_emits(1);
          phase_items++;
        end
        seg++;
      end
    end
    drain_points();

    $display("run covered %0d corner loads and %0d raster points over %0d register settings",
             tracker.loads_seen, tracker.points_checked, settings_used);
    $display("%0d raster passes ended, %0d mismatches", tracker.ends_flagged,
             tracker.mismatches);
    if (tracker.mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/hrpg_pkg.sv
src/hrpg_fifo.sv
src/hrpg_front.sv
src/hrpg_back.sv
src/hexahedron_raster_point_generator.sv
tb/hexahedron_raster_point_generator_test.sv
